### src/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Shared types, codes and character helpers for the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam logic [7:0] ESC_CODE = 8'h1b;
	localparam logic [4:0] HEX_NONE = 5'd16;

	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_NEWLINE   = 8'h0a;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_X         = 8'h78;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_BODY = 3'd1,
		MODE_ESC  = 3'd2,
		MODE_HEX1 = 3'd3,
		MODE_HEX2 = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		KIND_BYTE    = 3'd0,
		KIND_END     = 3'd1,
		KIND_NEWLINE = 3'd2,
		KIND_BADHEX  = 3'd3,
		KIND_EOI     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       eom;
	} in_word_t;

	typedef struct packed {
		logic       has;
		logic [7:0] data;
		kind_t      kind;
	} dec_res_t;

	function automatic logic is_space(input logic [7:0] c);
		logic r;
		r = (c == CH_SPACE) || (c inside {[8'h09:8'h0d]});
		return r;
	endfunction

	// Returns HEX_NONE when the character is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		if (c inside {[8'h30:8'h39]}) begin
			v = 5'(c - 8'h30);
		end else if (c inside {[8'h41:8'h46]}) begin
			v = 5'(c - 8'h41 + 8'd10);
		end else if (c inside {[8'h61:8'h66]}) begin
			v = 5'(c - 8'h61 + 8'd10);
		end else begin
			v = HEX_NONE;
		end
		return v;
	endfunction

	function automatic logic [7:0] escape_map(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h61:   r = 8'h07;
			8'h62:   r = 8'h08;
			8'h66:   r = 8'h0c;
			8'h6e:   r = 8'h0a;
			8'h72:   r = 8'h0d;
			8'h74:   r = 8'h09;
			8'h76:   r = 8'h0b;
			8'h65:   r = ESC_CODE;
			default: r = c;
		endcase
		return r;
	endfunction

endpackage

### src/sed_in_reg.sv
// ----------------------------------------------------------------------------
// sed_in_reg
// Input register stage that captures one character word per cycle while it is empty or its word moves on.
// ----------------------------------------------------------------------------
module sed_in_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      char_in,
	input  logic            end_mark,
	input  logic            adv,
	output logic            valid_s1,
	output sed_pkg::in_word_t word_s1
);
	import sed_pkg::*;

	logic valid_q;

	assign in_ready = !valid_q || adv;
	assign valid_s1 = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1.ch  <= char_in;
			word_s1.eom <= end_mark;
		end
	end

endmodule

### src/sed_decode.sv
// ----------------------------------------------------------------------------
// sed_decode
// Decoding state machine that turns one character word into at most one result.
// ----------------------------------------------------------------------------
module sed_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  sed_pkg::in_word_t  word,
	output sed_pkg::dec_res_t  res
);
	import sed_pkg::*;

	mode_t      mode_q, mode_d;
	logic [3:0] hex_q, hex_d;
	logic [4:0] hv;

	assign hv = hex_value(word.ch);

	always_comb begin
		mode_d = mode_q;
		hex_d  = hex_q;
		case (mode_q)
			MODE_BODY: begin
				if (word.eom) begin
					mode_d = MODE_IDLE;
				end else if (word.ch == CH_BACKSLASH) begin
					mode_d = MODE_ESC;
				end else if (word.ch == CH_QUOTE || word.ch == CH_NEWLINE) begin
					mode_d = MODE_IDLE;
				end
			end
			MODE_ESC: begin
				if (word.eom) begin
					mode_d = MODE_IDLE;
				end else if (word.ch == CH_X) begin
					mode_d = MODE_HEX1;
				end else begin
					mode_d = MODE_BODY;
				end
			end
			MODE_HEX1: begin
				if (word.eom || hv[4]) begin
					mode_d = MODE_IDLE;
				end else begin
					mode_d = MODE_HEX2;
					hex_d  = hv[3:0];
				end
			end
			MODE_HEX2: begin
				if (word.eom || hv[4]) begin
					mode_d = MODE_IDLE;
				end else begin
					mode_d = MODE_BODY;
				end
			end
			default: begin
				if (word.eom || is_space(word.ch)) begin
					mode_d = MODE_IDLE;
				end else begin
					mode_d = MODE_BODY;
				end
			end
		endcase
	end

	always_comb begin
		res.has  = 1'b0;
		res.data = 8'h00;
		res.kind = KIND_BYTE;
		case (mode_q)
			MODE_BODY: begin
				if (word.eom) begin
					res.has  = 1'b1;
					res.kind = KIND_EOI;
				end else if (word.ch == CH_QUOTE) begin
					res.has  = 1'b1;
					res.kind = KIND_END;
				end else if (word.ch == CH_NEWLINE) begin
					res.has  = 1'b1;
					res.kind = KIND_NEWLINE;
				end else if (word.ch != CH_BACKSLASH) begin
					res.has  = 1'b1;
					res.data = word.ch;
				end
			end
			MODE_ESC: begin
				if (word.eom) begin
					res.has  = 1'b1;
					res.kind = KIND_EOI;
				end else if (word.ch != CH_X) begin
					res.has  = 1'b1;
					res.data = escape_map(word.ch);
				end
			end
			MODE_HEX1: begin
				if (word.eom) begin
					res.has  = 1'b1;
					res.kind = KIND_EOI;
				end else if (hv[4]) begin
					res.has  = 1'b1;
					res.kind = KIND_BADHEX;
				end
			end
			MODE_HEX2: begin
				res.has = 1'b1;
				if (word.eom) begin
					res.kind = KIND_EOI;
				end else if (hv[4]) begin
					res.kind = KIND_BADHEX;
				end else begin
					res.data = {hex_q, hv[3:0]};
				end
			end
			default: begin
				res.has = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			hex_q  <= 4'h0;
		end else if (take) begin
			mode_q <= mode_d;
			hex_q  <= hex_d;
		end
	end

endmodule

### src/sed_out_reg.sv
// ----------------------------------------------------------------------------
// sed_out_reg
// Result register that holds one decoded word until the consumer takes it.
// ----------------------------------------------------------------------------
module sed_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  sed_pkg::dec_res_t res,
	output logic              can_take,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        byte_out,
	output logic [2:0]        kind
);
	import sed_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	kind_t      kind_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign byte_out  = data_q;
	assign kind      = kind_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_take) begin
			valid_q <= load && res.has;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && load && res.has) begin
			data_q <= res.data;
			kind_q <= res.kind;
		end
	end

endmodule

### src/string_escape_decoder_top.sv
// ----------------------------------------------------------------------------
// string_escape_decoder_top
// Decodes a quoted C-style string literal, one raw character word per cycle while the output keeps up.
// ----------------------------------------------------------------------------
//   Channel  Handshake             Word
//   input    in_valid / in_ready   char_in, end_mark
//   output   out_valid / out_ready byte_out, kind
//
// One input word is accepted every cycle while the output side keeps up.
// An accepted word is held in the input register and is decoded into the
// result register when that register can take it; the result is then offered
// from the result register. The decoding state advances only when the result
// register can take the outcome. A stalled output holds both stages, and
// arst_n returns the decoder to the idle mode with both stages empty.
// ----------------------------------------------------------------------------
module string_escape_decoder_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_mark,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] byte_out,
	output logic [2:0] kind
);
	import sed_pkg::*;

	logic      valid_s1;
	in_word_t  word_s1;
	dec_res_t  res;
	logic      can_take;
	logic      take;

	assign take = valid_s1 && can_take;

	sed_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.end_mark (end_mark),
		.adv      (can_take),
		.valid_s1 (valid_s1),
		.word_s1  (word_s1)
	);

	sed_decode u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (word_s1),
		.res    (res)
	);

	sed_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.res       (res),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_out  (byte_out),
		.kind      (kind)
	);

endmodule

### dv/string_escape_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder_checker
// Watches both channels of the string escape decoder. Every accepted input
// word is run through a local model of the decoding state machine. Each
// accepted output word is compared, field by field, with the oldest
// prediction. The failure count and the number of outstanding predictions
// are handed back to the testbench top.
// ----------------------------------------------------------------------------
module string_escape_decoder_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] char_in,
	input  logic       end_mark,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] byte_out,
	input  logic [2:0] kind,
	output int         fail_count,
	output int         pending
);
	import sed_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
	} dec_word_t;

	mode_t      str_mode;
	logic [3:0] high_nibble;
	dec_word_t  expected_words[$];
	dec_word_t  oldest;
	int         errors;

	function automatic logic hex_digit(input logic [7:0] c, output logic [3:0] v);
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end else begin
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] unescape(input logic [7:0] c);
		case (c)
			8'h61:   return 8'h07;
			8'h62:   return 8'h08;
			8'h66:   return 8'h0c;
			8'h6e:   return 8'h0a;
			8'h72:   return 8'h0d;
			8'h74:   return 8'h09;
			8'h76:   return 8'h0b;
			8'h65:   return ESC_CODE;
			default: return c;
		endcase
	endfunction

	task automatic expect_word(input logic [7:0] data, input kind_t k);
		dec_word_t w;
		w.data = data;
		w.kind = k;
		expected_words.push_back(w);
	endtask

	task automatic decode_char(input logic [7:0] ch, input logic eom);
		logic [3:0] v;
		logic       ok;
		ok = hex_digit(ch, v);
		if (str_mode != MODE_IDLE && eom) begin
			str_mode = MODE_IDLE;
			expect_word(8'h00, KIND_EOI);
		end else begin
			case (str_mode)
				MODE_BODY: begin
					if (ch == CH_BACKSLASH) begin
						str_mode = MODE_ESC;
					end else if (ch == CH_QUOTE) begin
						str_mode = MODE_IDLE;
						expect_word(8'h00, KIND_END);
					end else if (ch == CH_NEWLINE) begin
						str_mode = MODE_IDLE;
						expect_word(8'h00, KIND_NEWLINE);
					end else begin
						expect_word(ch, KIND_BYTE);
					end
				end
				MODE_ESC: begin
					if (ch == CH_X) begin
						str_mode = MODE_HEX1;
					end else begin
						str_mode = MODE_BODY;
						expect_word(unescape(ch), KIND_BYTE);
					end
				end
				MODE_HEX1: begin
					if (!ok) begin
						str_mode = MODE_IDLE;
						expect_word(8'h00, KIND_BADHEX);
					end else begin
						high_nibble = v;
						str_mode = MODE_HEX2;
					end
				end
				MODE_HEX2: begin
					if (!ok) begin
						str_mode = MODE_IDLE;
						expect_word(8'h00, KIND_BADHEX);
					end else begin
						str_mode = MODE_BODY;
						expect_word({high_nibble, v}, KIND_BYTE);
					end
				end
				default: begin
					if (eom || ch == CH_SPACE || (ch >= 8'h09 && ch <= 8'h0d)) begin
						str_mode = MODE_IDLE;
					end else begin
						str_mode = MODE_BODY;
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_mode = MODE_IDLE;
			high_nibble = 4'd0;
			expected_words.delete();
			errors = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$error("unexpected output word: byte_out %02h, kind %0d", byte_out, kind);
					errors++;
				end else begin
					oldest = expected_words.pop_front();
					if (byte_out !== oldest.data) begin
						$error("byte_out: expected %02h, actual %02h", oldest.data, byte_out);
						errors++;
					end
					if (kind !== oldest.kind) begin
						$error("kind: expected %0d, actual %0d", oldest.kind, kind);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				decode_char(char_in, end_mark);
			end
			pending <= expected_words.size();
			fail_count <= errors;
		end
	end

endmodule

### dv/string_escape_decoder_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// string_escape_decoder_top_tb
// Drives the string escape decoder with a short directed sequence and then
// with random quoted strings, broken strings and noise, in phases with and
// without idling on either channel. A checker beside the block predicts and
// compares every output word; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module string_escape_decoder_top_tb;
	import sed_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_WORDS = 150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] char_in = 8'h00;
	logic       end_mark = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] byte_out;
	logic [2:0] kind;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int word_count = 0;
	int cycle_count = 0;

	logic [8:0] directed_words [0:26];

	string_escape_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_in   (char_in),
		.end_mark  (end_mark),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.byte_out  (byte_out),
		.kind      (kind)
	);

	string_escape_decoder_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_in    (char_in),
		.end_mark   (end_mark),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_out   (byte_out),
		.kind       (kind),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		forever begin
			#2 clk = ~clk;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic send_word(input logic [7:0] ch, input logic eom);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do begin
				@(posedge clk);
			end while ($urandom_range(0, 99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		char_in <= ch;
		end_mark <= eom;
		word_count++;
		do begin
			@(posedge clk);
		end while (!(in_valid && in_ready));
	endtask

	function automatic logic [7:0] hex_char();
		logic [3:0] v;
		v = 4'($urandom_range(0, 15));
		if (v < 10) begin
			return 8'h30 + v;
		end else if ($urandom_range(0, 1)) begin
			return 8'h37 + v;
		end else begin
			return 8'h57 + v;
		end
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66));
		return c;
	endfunction

	task automatic send_string();
		logic [7:0] c;
		int         k;
		repeat ($urandom_range(0, 2)) begin
			k = $urandom_range(0, 5);
			send_word((k == 5) ? CH_SPACE : 8'(8'h09 + k), 1'b0);
		end
		if ($urandom_range(0, 3) != 0) begin
			c = CH_QUOTE;
		end else begin
			do begin
				c = 8'($urandom_range(0, 255));
			end while (c == CH_SPACE || (c >= 8'h09 && c <= 8'h0d));
		end
		send_word(c, 1'b0);
		repeat ($urandom_range(0, 6)) begin
			k = $urandom_range(0, 9);
			if (k < 5) begin
				do begin
					c = 8'($urandom_range(0, 255));
				end while (c == CH_BACKSLASH || c == CH_QUOTE || c == CH_NEWLINE);
				send_word(c, 1'b0);
			end else if (k < 7) begin
				send_word(CH_BACKSLASH, 1'b0);
				case ($urandom_range(0, 10))
					0:       c = 8'h27;
					1:       c = CH_QUOTE;
					2:       c = CH_BACKSLASH;
					3:       c = 8'h61;
					4:       c = 8'h62;
					5:       c = 8'h66;
					6:       c = 8'h6e;
					7:       c = 8'h72;
					8:       c = 8'h74;
					9:       c = 8'h76;
					default: c = 8'h65;
				endcase
				send_word(c, 1'b0);
			end else if (k == 7) begin
				send_word(CH_BACKSLASH, 1'b0);
				do begin
					c = 8'($urandom_range(0, 255));
				end while (c == CH_X);
				send_word(c, 1'b0);
			end else begin
				send_word(CH_BACKSLASH, 1'b0);
				send_word(CH_X, 1'b0);
				send_word(hex_char(), 1'b0);
				send_word(hex_char(), 1'b0);
			end
		end
		k = $urandom_range(0, 9);
		if (k < 6) begin
			send_word(CH_QUOTE, 1'b0);
		end else if (k == 6) begin
			send_word(CH_NEWLINE, 1'b0);
		end else if (k == 7) begin
			k = $urandom_range(0, 3);
			if (k > 0) begin
				send_word(CH_BACKSLASH, 1'b0);
			end
			if (k > 1) begin
				send_word(CH_X, 1'b0);
			end
			if (k > 2) begin
				send_word(hex_char(), 1'b0);
			end
			send_word(8'($urandom_range(0, 255)), 1'b1);
		end else begin
			send_word(CH_BACKSLASH, 1'b0);
			send_word(CH_X, 1'b0);
			if (k == 9) begin
				send_word(hex_char(), 1'b0);
			end
			send_word(non_hex_char(), 1'b0);
		end
	endtask

	task automatic send_noise();
		repeat ($urandom_range(1, 4)) begin
			send_word(8'($urandom_range(0, 255)), ($urandom_range(0, 9) == 0));
		end
	endtask

	initial begin
		int phase;
		int target;
		directed_words = '{
			9'h020, 9'h009, 9'h1ff, 9'h022, 9'h000, 9'h0ff, 9'h05c, 9'h00a, 9'h05c,
			9'h078, 9'h041, 9'h066, 9'h022, 9'h027, 9'h00a, 9'h022, 9'h05c, 9'h078,
			9'h067, 9'h022, 9'h05c, 9'h078, 9'h037, 9'h03a, 9'h0ff, 9'h05c, 9'h100
		};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_words[i]) begin
			send_word(directed_words[i][7:0], directed_words[i][8]);
		end
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 28;
					recv_stall_pct = 28;
				end
			endcase
			target = word_count + PHASE_WORDS;
			while (word_count < target) begin
				if ($urandom_range(0, 9) < 8) begin
					send_string();
				end else begin
					send_noise();
				end
			end
		end
		in_valid <= 1'b0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

endmodule

### files.f
src/sed_pkg.sv
src/sed_in_reg.sv
src/sed_decode.sv
src/sed_out_reg.sv
src/string_escape_decoder_top.sv
dv/string_escape_decoder_checker.sv
dv/string_escape_decoder_top_tb.sv
